// ===== rtl/dwas_pkg.sv =====
// ----------------------------------------------------------------------------
// dwas_pkg - shared types and constants of the window address sequencer
// Function codes, panel register words, the job descriptor passed from the
// front part to the back part, and the queue status group.
// ----------------------------------------------------------------------------
package dwas_pkg;

  // default coordinate width
  localparam int unsigned COORD_BITS_DEF = 8;

  // input function codes
  localparam logic [2:0] FUNC_SET_ROT   = 3'd0;
  localparam logic [2:0] FUNC_SET_POS   = 3'd1;
  localparam logic [2:0] FUNC_SET_WIN   = 3'd2;
  localparam logic [2:0] FUNC_RESET_WIN = 3'd3;
  localparam logic [2:0] FUNC_PIXEL     = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [8:0] SCREEN_WIDTH_RST  = 9'd176;
  localparam logic [8:0] SCREEN_HEIGHT_RST = 9'd220;

  // rotation codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_CCW  = 2'd3;

  // panel command and data words
  localparam logic [15:0] CMD_DISP_CTRL = 16'h0007;
  localparam logic [15:0] CMD_ENTRY     = 16'h0005;
  localparam logic [15:0] CMD_ADDR      = 16'h0021;
  localparam logic [15:0] CMD_GRAM      = 16'h0022;
  localparam logic [15:0] DISP_NONE     = 16'h0804;
  localparam logic [15:0] DISP_CW       = 16'h0A04;
  localparam logic [15:0] DISP_180      = 16'h0E04;
  localparam logic [15:0] DISP_CCW      = 16'h0C04;
  localparam logic [15:0] ENTRY_ROWS    = 16'h0030;
  localparam logic [15:0] ENTRY_COLS    = 16'h0038;

  // job queue
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    JOB_ROT      = 2'd0,  // five words
    JOB_ADDR     = 2'd1,  // three words
    JOB_PIX      = 2'd2,  // one word
    JOB_PIX_ADDR = 2'd3   // four words
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  rot;
    logic [15:0] color;
    logic [15:0] addr;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/display_window_address_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// display_window_address_sequencer_core - panel write sequencer top level
// Turns rotation, position, window and pixel transactions into the command
// and data words for a panel with a windowed graphics memory.
// ----------------------------------------------------------------------------
// Every transaction is taken when accepted: the front part updates rotation,
// cursor and window at once and queues a job, so a new transaction may follow
// in the very next cycle while earlier words are still going out. The back
// part sends one bus word per cycle, while the bus side is ready, from a
// single output register: a pixel write that stays inside the window costs
// one word, a pixel write that wraps four, a position, window set or window
// reset three, and a rotation change five. Sustained throughput is therefore
// one word per cycle on the output side while the bus is ready, which gives
// one pixel transaction per cycle in the steady state; wrap and rotation
// bursts are soaked up by a four-job queue and the input stalls only when
// that queue is full. Unknown function codes are accepted and produce nothing.
// Configuration writes are always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
module display_window_address_sequencer_core #(
  parameter int unsigned COORD_BITS = dwas_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_func,
  input  logic [7:0]                        in_first_x,
  input  logic [7:0]                        in_first_y,
  input  logic [7:0]                        in_second_x,
  input  logic [7:0]                        in_second_y,
  input  logic [1:0]                        in_rot_code,
  input  logic [15:0]                       in_pixel_color,
  // bus words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_is_command,
  output logic [15:0]                       out_bus_word,
  output logic                              out_last_word,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dwas_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [8:0]                        cfg_data
);
  import dwas_pkg::*;

  // front to queue
  logic    q_push;
  job_t    q_job;
  // queue to back
  job_t    head_job;
  q_stat_t q_stat;
  logic    q_pop;

  // decode and state update, one transaction per cycle while the queue has room
  dwas_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .in_rot_code    (in_rot_code),
    .in_pixel_color (in_pixel_color),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_job          (q_job)
  );

  // decouples transaction intake from word output
  dwas_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // expands each job into its bus words
  dwas_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_command (out_is_command),
    .out_bus_word   (out_bus_word),
    .out_last_word  (out_last_word)
  );

endmodule

// ===== rtl/dwas_front.sv =====
// ----------------------------------------------------------------------------
// dwas_front - transaction decode and sequencer state
// Holds rotation, cursor and window, applies each transaction to them in the
// cycle it is accepted and pushes a job describing the words to emit.
// ----------------------------------------------------------------------------
module dwas_front #(
  parameter int unsigned COORD_BITS = dwas_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_func,
  input  logic [7:0]                           in_first_x,
  input  logic [7:0]                           in_first_y,
  input  logic [7:0]                           in_second_x,
  input  logic [7:0]                           in_second_y,
  input  logic [1:0]                           in_rot_code,
  input  logic [15:0]                          in_pixel_color,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dwas_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [8:0]                           cfg_data,
  input  dwas_pkg::q_stat_t                    q_stat,
  output logic                                 q_push,
  output dwas_pkg::job_t                       q_job
);
  import dwas_pkg::*;

  localparam logic [8:0] EDGE_MAX = 9'((1 << COORD_BITS) - 1);

  logic [8:0]            scr_w_r, scr_w_nxt, scr_h_r, scr_h_nxt;
  logic [1:0]            rot_r, rot_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] win_l_r, win_l_nxt, win_t_r, win_t_nxt;
  logic [COORD_BITS-1:0] win_r_r, win_r_nxt, win_b_r, win_b_nxt;

  logic                  accept, swap, wrap;
  logic [COORD_BITS-1:0] ax, ay, bx, by, px, py, qx, qy;
  logic [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y, adv_x, adv_y;

  // size to far edge, saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] size_edge(input logic [8:0] size);
    logic [8:0] e;
    e = size - 9'd1;
    if (size == 9'd0) return '0;
    if (e > EDGE_MAX) return '1;
    return e[COORD_BITS-1:0];
  endfunction

  function automatic logic [15:0] addr_word(input logic [COORD_BITS-1:0] x,
                                            input logic [COORD_BITS-1:0] y);
    return (16'(y) << 8) | 16'(x);
  endfunction

  assign in_ready  = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign swap      = rot_r[0];

  assign ax = in_first_x[COORD_BITS-1:0];
  assign ay = in_first_y[COORD_BITS-1:0];
  assign bx = in_second_x[COORD_BITS-1:0];
  assign by = in_second_y[COORD_BITS-1:0];

  // user to panel coordinates
  assign px = swap ? ay : ax;
  assign py = swap ? ax : ay;
  assign qx = swap ? by : bx;
  assign qy = swap ? bx : by;

  assign lo_x = (px > qx) ? qx : px;
  assign hi_x = (px > qx) ? px : qx;
  assign lo_y = (py > qy) ? qy : py;
  assign hi_y = (py > qy) ? py : qy;

  // cursor advance inside the window
  always_comb begin
    adv_x = cur_x_r;
    adv_y = cur_y_r;
    wrap  = 1'b0;
    if (!swap) begin
      if (cur_x_r >= win_r_r) begin
        wrap  = 1'b1;
        adv_x = win_l_r;
        adv_y = (cur_y_r >= win_b_r) ? win_t_r : cur_y_r + 1'b1;
      end else begin
        adv_x = cur_x_r + 1'b1;
      end
    end else begin
      if (cur_y_r >= win_b_r) begin
        wrap  = 1'b1;
        adv_y = win_t_r;
        adv_x = (cur_x_r >= win_r_r) ? win_l_r : cur_x_r + 1'b1;
      end else begin
        adv_y = cur_y_r + 1'b1;
      end
    end
  end

  always_comb begin
    scr_w_nxt = scr_w_r;
    scr_h_nxt = scr_h_r;
    rot_nxt   = rot_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    win_l_nxt = win_l_r;
    win_t_nxt = win_t_r;
    win_r_nxt = win_r_r;
    win_b_nxt = win_b_r;
    q_push    = 1'b0;
    q_job     = '{kind: JOB_PIX, rot: in_rot_code, color: in_pixel_color, addr: '0};

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_nxt = cfg_data;
        REG_SCREEN_HEIGHT: scr_h_nxt = cfg_data;
        default: ;
      endcase
    end

    if (accept) begin
      unique case (in_func)
        FUNC_SET_ROT: begin
          rot_nxt    = in_rot_code;
          q_push     = 1'b1;
          q_job.kind = JOB_ROT;
        end
        FUNC_SET_POS: begin
          cur_x_nxt  = px;
          cur_y_nxt  = py;
          q_push     = 1'b1;
          q_job.kind = JOB_ADDR;
          q_job.addr = addr_word(px, py);
        end
        FUNC_SET_WIN: begin
          win_l_nxt  = lo_x;
          win_t_nxt  = lo_y;
          win_r_nxt  = hi_x;
          win_b_nxt  = hi_y;
          cur_x_nxt  = lo_x;
          cur_y_nxt  = lo_y;
          q_push     = 1'b1;
          q_job.kind = JOB_ADDR;
          q_job.addr = addr_word(lo_x, lo_y);
        end
        FUNC_RESET_WIN: begin
          win_l_nxt  = '0;
          win_t_nxt  = '0;
          win_r_nxt  = size_edge(scr_w_r);
          win_b_nxt  = size_edge(scr_h_r);
          cur_x_nxt  = '0;
          cur_y_nxt  = '0;
          q_push     = 1'b1;
          q_job.kind = JOB_ADDR;
          q_job.addr = '0;
        end
        FUNC_PIXEL: begin
          cur_x_nxt  = adv_x;
          cur_y_nxt  = adv_y;
          q_push     = 1'b1;
          q_job.kind = wrap ? JOB_PIX_ADDR : JOB_PIX;
          q_job.addr = addr_word(adv_x, adv_y);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_WIDTH_RST;
      scr_h_r <= SCREEN_HEIGHT_RST;
      rot_r   <= ROT_NONE;
      cur_x_r <= '0;
      cur_y_r <= '0;
      win_l_r <= '0;
      win_t_r <= '0;
      win_r_r <= '1;
      win_b_r <= '1;
    end else begin
      scr_w_r <= scr_w_nxt;
      scr_h_r <= scr_h_nxt;
      rot_r   <= rot_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      win_l_r <= win_l_nxt;
      win_t_r <= win_t_nxt;
      win_r_r <= win_r_nxt;
      win_b_r <= win_b_nxt;
    end
  end

  // a job leaves only for an accepted transaction with a known function
  a_push_known: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> accept && (in_func <= FUNC_PIXEL))
    else $error("job pushed without a known accepted transaction");

  // a window set always leaves sorted corners
  a_win_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_func == FUNC_SET_WIN) |=> (win_l_r <= win_r_r) && (win_t_r <= win_b_r))
    else $error("window corners not sorted");

endmodule

// ===== rtl/dwas_queue.sv =====
// ----------------------------------------------------------------------------
// dwas_queue - job queue between front and back
// Small first-in first-out buffer of job descriptors.
// ----------------------------------------------------------------------------
module dwas_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dwas_pkg::job_t    push_job,
  input  logic              pop,
  output dwas_pkg::job_t    head_job,
  output dwas_pkg::q_stat_t stat
);
  import dwas_pkg::*;

  job_t                      mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_BITS:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full job queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty job queue");

endmodule

// ===== rtl/dwas_back.sv =====
// ----------------------------------------------------------------------------
// dwas_back - bus word sequencer
// Walks the job at the queue head one word per cycle, while the bus side is
// ready, into the output register and pops the job with its last word.
// ----------------------------------------------------------------------------
module dwas_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dwas_pkg::job_t    head_job,
  input  dwas_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_command,
  output logic [15:0]       out_bus_word,
  output logic              out_last_word
);
  import dwas_pkg::*;

  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        is_cmd_r, last_r;
  logic [15:0] word_r;
  logic        load, g_cmd, g_last;
  logic [15:0] g_word, disp_word;
  logic [1:0]  aidx;

  always_comb begin
    unique case (head_job.rot)
      ROT_NONE: disp_word = DISP_NONE;
      ROT_CW:   disp_word = DISP_CW;
      ROT_180:  disp_word = DISP_180;
      ROT_CCW:  disp_word = DISP_CCW;
      default:  disp_word = DISP_NONE;
    endcase
  end

  // address sequence index, shifted by the leading pixel word
  assign aidx = (head_job.kind == JOB_PIX_ADDR) ? 2'(step_r - 3'd1) : step_r[1:0];

  always_comb begin
    g_cmd  = 1'b0;
    g_word = head_job.color;
    g_last = 1'b0;
    unique case (head_job.kind) inside
      JOB_ROT: begin
        case (step_r)
          3'd0:    begin g_cmd = 1'b1; g_word = CMD_DISP_CTRL; end
          3'd1:    g_word = disp_word;
          3'd2:    begin g_cmd = 1'b1; g_word = CMD_ENTRY; end
          3'd3:    g_word = head_job.rot[0] ? ENTRY_COLS : ENTRY_ROWS;
          default: begin g_cmd = 1'b1; g_word = CMD_GRAM; g_last = 1'b1; end
        endcase
      end
      JOB_PIX: g_last = 1'b1;
      JOB_ADDR, JOB_PIX_ADDR: begin
        if (!((head_job.kind == JOB_PIX_ADDR) && (step_r == 3'd0))) begin
          case (aidx)
            2'd0:    begin g_cmd = 1'b1; g_word = CMD_ADDR; end
            2'd1:    g_word = head_job.addr;
            default: begin g_cmd = 1'b1; g_word = CMD_GRAM; g_last = 1'b1; end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign load          = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop           = load && g_last;
  assign step_nxt      = load ? (g_last ? 3'd0 : step_r + 3'd1) : step_r;
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_cmd_r <= g_cmd;
      word_r   <= g_word;
      last_r   <= g_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_command = is_cmd_r;
  assign out_bus_word   = word_r;
  assign out_last_word  = last_r;

  // the word index stays inside the longest job
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 3'd4)
    else $error("word index beyond job length");

  // a single-word job is always taken at its first word
  a_pix_first: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty && (head_job.kind == JOB_PIX) |-> step_r == 3'd0)
    else $error("pixel job seen mid sequence");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench of the display window address sequencer
// Drives rotation, position, window and pixel transactions with random gaps,
// stalls the bus side at random and checks every bus word against a
// scoreboard that predicts the panel command and data stream.
// ----------------------------------------------------------------------------

import dwas_pkg::*;

typedef struct {
  logic [2:0]  func;
  logic [7:0]  first_x;
  logic [7:0]  first_y;
  logic [7:0]  second_x;
  logic [7:0]  second_y;
  logic [1:0]  rot_code;
  logic [15:0] color;
} panel_op_t;

typedef struct {
  logic        is_cmd;
  logic [15:0] word;
  logic        last;
} bus_xfer_t;

// panel state mirror and queue of bus words still to come
class window_scoreboard;
  logic [8:0] width_reg;
  logic [8:0] height_reg;
  logic [1:0] rot_mode;
  logic [7:0] cur_x;
  logic [7:0] cur_y;
  logic [7:0] win_l;
  logic [7:0] win_t;
  logic [7:0] win_r;
  logic [7:0] win_b;
  bus_xfer_t  word_q[$];
  int         mismatches;

  function new();
    width_reg  = SCREEN_WIDTH_RST;
    height_reg = SCREEN_HEIGHT_RST;
    rot_mode   = ROT_NONE;
    cur_x      = 8'd0;
    cur_y      = 8'd0;
    win_l      = 8'd0;
    win_t      = 8'd0;
    win_r      = 8'hFF;
    win_b      = 8'hFF;
    mismatches = 0;
  endfunction

  function bit axes_swapped();
    return rot_mode == ROT_CW || rot_mode == ROT_CCW;
  endfunction

  // far window edge from a panel size, clamped to the coordinate range
  function logic [7:0] far_edge(logic [8:0] size);
    if (size == 9'd0) return 8'd0;
    if (size > 9'd256) return 8'hFF;
    return 8'(size - 9'd1);
  endfunction

  function void push_word(logic is_cmd, logic [15:0] word);
    bus_xfer_t w;
    w.is_cmd = is_cmd;
    w.word   = word;
    w.last   = 1'b0;
    word_q.push_back(w);
  endfunction

  function void push_address(logic [7:0] x, logic [7:0] y);
    push_word(1'b1, CMD_ADDR);
    push_word(1'b0, {y, x});
    push_word(1'b1, CMD_GRAM);
    cur_x = x;
    cur_y = y;
  endfunction

  function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [8:0] value);
    if (idx == REG_SCREEN_WIDTH) width_reg = value;
    else if (idx == REG_SCREEN_HEIGHT) height_reg = value;
  endfunction

  function void note_op(panel_op_t op);
    logic [7:0]  ax;
    logic [7:0]  ay;
    logic [7:0]  bx;
    logic [7:0]  by;
    logic [7:0]  t;
    logic [15:0] disp;
    int          first;
    first = word_q.size();
    ax = op.first_x;
    ay = op.first_y;
    bx = op.second_x;
    by = op.second_y;
    case (op.func)
      FUNC_SET_ROT: begin
        rot_mode = op.rot_code;
        case (op.rot_code)
          ROT_NONE: disp = DISP_NONE;
          ROT_CW:   disp = DISP_CW;
          ROT_180:  disp = DISP_180;
          default:  disp = DISP_CCW;
        endcase
        push_word(1'b1, CMD_DISP_CTRL);
        push_word(1'b0, disp);
        push_word(1'b1, CMD_ENTRY);
        push_word(1'b0, axes_swapped() ? ENTRY_COLS : ENTRY_ROWS);
        push_word(1'b1, CMD_GRAM);
      end
      FUNC_SET_POS: begin
        if (axes_swapped()) begin
          t = ax; ax = ay; ay = t;
        end
        push_address(ax, ay);
      end
      FUNC_SET_WIN: begin
        if (axes_swapped()) begin
          t = ax; ax = ay; ay = t;
          t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
          t = ax; ax = bx; bx = t;
        end
        if (ay > by) begin
          t = ay; ay = by; by = t;
        end
        win_l = ax;
        win_t = ay;
        win_r = bx;
        win_b = by;
        push_address(ax, ay);
      end
      FUNC_RESET_WIN: begin
        win_l = 8'd0;
        win_t = 8'd0;
        win_r = far_edge(width_reg);
        win_b = far_edge(height_reg);
        push_address(8'd0, 8'd0);
      end
      FUNC_PIXEL: begin
        push_word(1'b0, op.color);
        if (!axes_swapped()) begin
          if (cur_x >= win_r) push_address(win_l, (cur_y >= win_b) ? win_t : cur_y + 8'd1);
          else cur_x = cur_x + 8'd1;
        end else begin
          if (cur_y >= win_b) push_address((cur_x >= win_r) ? win_l : cur_x + 8'd1, win_t);
          else cur_y = cur_y + 8'd1;
        end
      end
      default: ;
    endcase
    if (word_q.size() > first) word_q[word_q.size() - 1].last = 1'b1;
  endfunction

  function void check_word(logic is_cmd, logic [15:0] word, logic last);
    bus_xfer_t want;
    if (word_q.size() == 0) begin
      $display("%0t: unexpected bus word cmd=%0b word=%h last=%0b", $time, is_cmd, word, last);
      mismatches++;
      return;
    end
    want = word_q.pop_front();
    if (want.is_cmd !== is_cmd || want.word !== word || want.last !== last) begin
      $display("%0t: bus word mismatch: expected cmd=%0b word=%h last=%0b, got cmd=%0b word=%h last=%0b",
               $time, want.is_cmd, want.word, want.last, is_cmd, word, last);
      mismatches++;
    end
  endfunction

  function int pending();
    return word_q.size();
  endfunction
endclass

module tb;

  localparam int CLK_HALF      = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 48;

  // function and register codes the block has no use for
  localparam logic [2:0]              FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0]              FUNC_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B      = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [2:0]              in_func;
  logic [7:0]              in_first_x;
  logic [7:0]              in_first_y;
  logic [7:0]              in_second_x;
  logic [7:0]              in_second_y;
  logic [1:0]              in_rot_code;
  logic [15:0]             in_pixel_color;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_is_command;
  logic [15:0]             out_bus_word;
  logic                    out_last_word;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [8:0]              cfg_data;

  window_scoreboard sb;
  int               cycle_count = 0;
  int               hold_off_left = 0;  // long bus hold-off, counted down by the receiver
  bit               no_gaps = 1'b0;     // sender offers back to back
  bit               drain_mode = 1'b0;  // bus side always ready at the end

  display_window_address_sequencer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .in_rot_code    (in_rot_code),
    .in_pixel_color (in_pixel_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_command (out_is_command),
    .out_bus_word   (out_bus_word),
    .out_last_word  (out_last_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // every bus transaction is checked against the oldest predicted word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_is_command, out_bus_word, out_last_word);
  end

  // bus side: runs of ready, short stalls, now and then a long one
  initial begin
    int r;
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (drain_mode) begin
        out_ready = 1'b1;
      end else if (hold_off_left > 0) begin
        out_ready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready = 1'b1;
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) run_left = $urandom_range(1, 24);
        else if (r < 95) stall_left = $urandom_range(0, 2);
        else stall_left = $urandom_range(8, 30);
        out_ready = (r < 65);
      end
    end
  end

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic panel_op_t make_op(logic [2:0] func, logic [7:0] ax, logic [7:0] ay,
                                        logic [7:0] bx, logic [7:0] by, logic [1:0] rot,
                                        logic [15:0] color);
    panel_op_t op;
    op.func     = func;
    op.first_x  = ax;
    op.first_y  = ay;
    op.second_x = bx;
    op.second_y = by;
    op.rot_code = rot;
    op.color    = color;
    return op;
  endfunction

  // mostly pixel streams into small windows so that wraps come often
  function automatic panel_op_t random_op();
    panel_op_t op;
    int        r;
    op.first_x  = 8'($urandom);
    op.first_y  = 8'($urandom);
    op.second_x = 8'($urandom);
    op.second_y = 8'($urandom);
    op.rot_code = 2'($urandom);
    op.color    = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      op.func = FUNC_PIXEL;
    end else if (r < 67) begin
      op.func = FUNC_SET_WIN;
      if ($urandom_range(0, 3) != 0) begin
        op.second_x = op.first_x + 8'($urandom_range(0, 3));
        op.second_y = op.first_y + 8'($urandom_range(0, 5));
      end
    end else if (r < 77) begin
      op.func = FUNC_SET_POS;
    end else if (r < 85) begin
      op.func = FUNC_RESET_WIN;
    end else if (r < 94) begin
      op.func = FUNC_SET_ROT;
    end else begin
      op.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    end
    return op;
  endfunction

  // one input transaction; called and left at a falling edge, valid kept
  // high when the next transaction follows at once
  task automatic send_op(input panel_op_t op);
    int gap;
    in_func        = op.func;
    in_first_x     = op.first_x;
    in_first_y     = op.first_y;
    in_second_x    = op.second_x;
    in_second_y    = op.second_y;
    in_rot_code    = op.rot_code;
    in_pixel_color = op.color;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_op(op);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [8:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let every predicted word come out, then give the back part time to settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // a phase opens with a window reset so the current panel size is used
  task automatic run_phase(input int count);
    send_op(make_op(FUNC_RESET_WIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    2'($urandom), 16'($urandom)));
    repeat (count) send_op(random_op());
  endtask

  initial begin
    panel_op_t op;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_SET_ROT;
    in_first_x     = 8'd0;
    in_first_y     = 8'd0;
    in_second_x    = 8'd0;
    in_second_y    = 8'd0;
    in_rot_code    = ROT_NONE;
    in_pixel_color = 16'd0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_SCREEN_WIDTH;
    cfg_data       = 9'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: pixels from the reset window, default panel size
    send_op(make_op(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE, 16'h0000));
    send_op(make_op(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ROT_CCW, 16'hFFFF));
    send_op(make_op(FUNC_RESET_WIN, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE, 16'h0000));
    // cursor beyond both far edges wraps to the top-left corner
    send_op(make_op(FUNC_SET_POS, 8'hFF, 8'hFF, 8'h00, 8'h00, ROT_NONE, 16'h0000));
    send_op(make_op(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE, 16'h5555));
    // corners given in reverse order, two by two at the top of the range
    send_op(make_op(FUNC_SET_WIN, 8'hFF, 8'hFF, 8'hFE, 8'hFE, ROT_NONE, 16'h0000));
    repeat (5) send_op(make_op(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE,
                               16'($urandom)));
    // ninety clockwise: swapped coordinates, column-major advance
    send_op(make_op(FUNC_SET_ROT, 8'h00, 8'h00, 8'h00, 8'h00, ROT_CW, 16'h0000));
    send_op(make_op(FUNC_SET_WIN, 8'd10, 8'd200, 8'd12, 8'd198, ROT_NONE, 16'h0000));
    repeat (4) send_op(make_op(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE,
                               16'hAAAA));
    send_op(make_op(FUNC_SET_POS, 8'd3, 8'd250, 8'h00, 8'h00, ROT_NONE, 16'h0000));
    send_op(make_op(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE, 16'h1234));
    send_op(make_op(FUNC_SET_ROT, 8'h00, 8'h00, 8'h00, 8'h00, ROT_180, 16'h0000));
    send_op(make_op(FUNC_SET_ROT, 8'h00, 8'h00, 8'h00, 8'h00, ROT_CCW, 16'h0000));
    send_op(make_op(FUNC_SET_WIN, 8'h00, 8'h00, 8'hFF, 8'hFF, ROT_NONE, 16'h0000));
    send_op(make_op(FUNC_SET_ROT, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE, 16'h0000));
    // unused function codes produce nothing
    send_op(make_op(FUNC_SPARE_FIRST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ROT_CCW, 16'hFFFF));
    send_op(make_op(FUNC_SPARE_LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ROT_CCW, 16'hFFFF));
    send_op(make_op(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, ROT_NONE, 16'hAAAA));

    run_phase(PHASE_ITEMS);

    // zero panel size clamps the far edge to the first column and row;
    // writes to unused indexes must change nothing
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, 9'd0);
    write_reg(REG_SCREEN_HEIGHT, 9'd0);
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'h0AA);
    run_phase(PHASE_ITEMS);

    // long bus hold-off while pixels keep coming, so the job queue fills
    // and the input side has to stall
    hold_off_left = 120;
    no_gaps = 1'b1;
    repeat (24) begin
      op = random_op();
      op.func = FUNC_PIXEL;
      send_op(op);
    end
    no_gaps = 1'b0;

    // smallest panel, sender back to back for the whole phase
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, 9'd1);
    write_reg(REG_SCREEN_HEIGHT, 9'd1);
    no_gaps = 1'b1;
    run_phase(PHASE_ITEMS);
    no_gaps = 1'b0;

    // full coordinate range
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, 9'd256);
    write_reg(REG_SCREEN_HEIGHT, 9'd256);
    run_phase(PHASE_ITEMS);

    // oversize panel saturates the far edge
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, 9'd511);
    write_reg(REG_SCREEN_HEIGHT, 9'd300);
    run_phase(PHASE_ITEMS);

    wait_idle();
    write_reg(REG_SCREEN_WIDTH, 9'($urandom_range(1, 255)));
    write_reg(REG_SCREEN_HEIGHT, 9'($urandom_range(1, 255)));
    run_phase(PHASE_ITEMS);

    // drain with the bus always ready so stray words still show up
    drain_mode = 1'b1;
    wait_idle();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
